// File: design/world_point_to_screen_cell_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the world point to screen cell projection
// Shared wrappers for the concurrent checks on the projection block.
// ---------------------------------------------------------------------------
`ifndef WORLD_POINT_TO_SCREEN_CELL_DEFINES_SVH
`define WORLD_POINT_TO_SCREEN_CELL_DEFINES_SVH

// Check that is switched off while reset is held.
`define WPSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that also runs through reset.
`define WPSC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: design/wpsc_pkg.sv
// ---------------------------------------------------------------------------
// wpsc_pkg
// Types, constants and helper functions of the screen cell projection.
// ---------------------------------------------------------------------------
package wpsc_pkg;

    localparam int WPSC_CELL_SCALE   = 2;
    localparam int WPSC_HEIGHT_RANGE = 16;
    localparam int QBITS             = 40;  // quotient bits, one per divider cell
    localparam int LOW_BITS          = 10;  // numerator bits fed into the divider
    localparam int FRAC              = 16;  // fraction bits of Q16.16

    typedef enum logic [2:0] {
        CFG_MODE     = 3'd0,
        CFG_X_COEF   = 3'd1,
        CFG_Y_COEF   = 3'd2,
        CFG_OFFSETS  = 3'd3,
        CFG_HEIGHT_Z = 3'd4,
        CFG_EYE_XY   = 3'd5,
        CFG_VIEW_DIR = 3'd6,
        CFG_CENTRE   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] a0;
        logic signed [31:0] a2;
        logic signed [31:0] a1;
        logic signed [31:0] a3;
        logic signed [31:0] b0;
        logic signed [31:0] b1;
        logic signed [31:0] a5;
        logic signed [31:0] eye_z;
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [31:0] cen_x;
        logic signed [31:0] cen_y;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic               visible;
        logic               neg_x;
        logic               neg_y;
        logic               ovf_x;
        logic               ovf_y;
        logic signed [15:0] aff_x;
        logic signed [15:0] aff_y;
        logic signed [15:0] height;
    } t_ctl;

    function automatic logic signed [15:0] f_sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    // Round half up to an integer, then floor((t - 1) / 2), saturated.
    function automatic logic signed [15:0] f_to_cell(input logic signed [63:0] v);
        logic signed [63:0] t;
        logic signed [63:0] c;
        t = (v + 64'sd32768) >>> FRAC;
        c = (t - 64'sd1) >>> 1;
        return f_sat16(c);
    endfunction

endpackage

// File: design/wpsc_front.sv
// ---------------------------------------------------------------------------
// wpsc_front
// Four pipeline stages: products, affine sums and distance terms, distance
// and centre offsets, then divider setup.
// ---------------------------------------------------------------------------
module wpsc_front import wpsc_pkg::*; #(
    parameter int CELL_SCALE   = WPSC_CELL_SCALE,
    parameter int HEIGHT_RANGE = WPSC_HEIGHT_RANGE,
    parameter int DW           = 56,
    parameter int NW           = 53
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_cfg                 i_cfg,
    input  logic signed [31:0]   i_world_x,
    input  logic signed [31:0]   i_world_y,
    input  logic signed [31:0]   i_world_z,
    output t_ctl                 o_ctl,
    output logic [DW-2:0]        o_den,
    output logic [DW-2:0]        o_rem_x,
    output logic [DW-2:0]        o_rem_y,
    output logic [LOW_BITS-1:0]  o_low_x,
    output logic [LOW_BITS-1:0]  o_low_y
);

    localparam int CS_BITS = $clog2(CELL_SCALE + 1);
    localparam int XW      = 32 + CS_BITS;
    localparam int EW      = XW + 1;
    localparam int PW      = EW + 16;
    localparam int SW      = NW - 1;
    localparam int CW      = DW - 1 + LOW_BITS;

    // stage 1
    logic                 r1_valid;
    logic signed [63:0]   r1_p0, r1_p2, r1_p1, r1_p3, r1_p5;
    logic signed [EW-1:0] r1_dx, r1_dy, r1_dz;
    logic signed [15:0]   r1_h;
    logic signed [XW-1:0] w_xs, w_ys;
    logic signed [63:0]   w_h;

    assign w_xs = XW'(i_world_x) * XW'(CELL_SCALE);
    assign w_ys = XW'(i_world_y) * XW'(CELL_SCALE);
    assign w_h  = ((64'(i_world_z) + 64'sd32768) >>> FRAC) + 64'(HEIGHT_RANGE / 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p0 <= i_cfg.a0 * i_world_x;
            r1_p2 <= i_cfg.a2 * i_world_y;
            r1_p1 <= i_cfg.a1 * i_world_x;
            r1_p3 <= i_cfg.a3 * i_world_y;
            r1_p5 <= i_cfg.a5 * i_world_z;
            r1_dx <= EW'(w_xs) - EW'(i_cfg.eye_x);
            r1_dy <= EW'(w_ys) - EW'(i_cfg.eye_y);
            r1_dz <= EW'(i_world_z) - EW'(i_cfg.eye_z);
            r1_h  <= f_sat16(w_h);
        end
    end

    // stage 2
    logic                 r2_valid;
    logic signed [SW-1:0] r2_sx, r2_sy;
    logic signed [PW-1:0] r2_px, r2_py, r2_pz;
    logic signed [15:0]   r2_h;
    logic signed [SW-1:0] w_t0, w_t2, w_t1, w_t3;

    assign w_t0 = SW'(r1_p0 >>> FRAC) * SW'(CELL_SCALE);
    assign w_t2 = SW'(r1_p2 >>> FRAC) * SW'(CELL_SCALE);
    assign w_t1 = SW'(r1_p1 >>> FRAC) * SW'(CELL_SCALE);
    assign w_t3 = SW'(r1_p3 >>> FRAC) * SW'(CELL_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_sx <= w_t0 + w_t2 + SW'(i_cfg.b0);
            r2_sy <= w_t1 + w_t3 + SW'(r1_p5 >>> FRAC) + SW'(i_cfg.b1);
            r2_px <= PW'(r1_dx) * PW'(i_cfg.dir_x);
            r2_py <= PW'(r1_dy) * PW'(i_cfg.dir_y);
            r2_pz <= PW'(r1_dz) * PW'(i_cfg.dir_z);
            r2_h  <= r1_h;
        end
    end

    // stage 3
    logic                 r3_valid;
    logic signed [DW-1:0] r3_d;
    logic signed [NW-1:0] r3_ex, r3_ey;
    logic signed [15:0]   r3_h, r3_ax, r3_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_d  <= DW'(r2_px) + DW'(r2_py) + DW'(r2_pz);
            r3_ex <= NW'(r2_sx) - NW'(i_cfg.cen_x);
            r3_ey <= NW'(r2_sy) - NW'(i_cfg.cen_y);
            r3_ax <= f_to_cell(64'(r2_sx));
            r3_ay <= f_to_cell(64'(r2_sy));
            r3_h  <= r2_h;
        end
    end

    // stage 4: magnitudes, overflow test and the divider's first remainder
    logic [NW-1:0] w_mx, w_my;
    logic [DW-2:0] w_den;
    logic [CW-1:0] w_lim;
    t_ctl          r4_ctl;
    logic [DW-2:0] r4_den, r4_rem_x, r4_rem_y;
    logic [LOW_BITS-1:0] r4_low_x, r4_low_y;

    assign w_mx  = r3_ex[NW-1] ? (~r3_ex + 1'b1) : r3_ex;
    assign w_my  = r3_ey[NW-1] ? (~r3_ey + 1'b1) : r3_ey;
    assign w_den = r3_d[DW-2:0];
    assign w_lim = CW'(w_den) << LOW_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r4_ctl.valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ctl.visible <= !r3_d[DW-1] && (r3_d != '0);
            r4_ctl.neg_x   <= r3_ex[NW-1];
            r4_ctl.neg_y   <= r3_ey[NW-1];
            r4_ctl.ovf_x   <= CW'(w_mx) >= w_lim;
            r4_ctl.ovf_y   <= CW'(w_my) >= w_lim;
            r4_ctl.aff_x   <= r3_ax;
            r4_ctl.aff_y   <= r3_ay;
            r4_ctl.height  <= r3_h;
            r4_den         <= w_den;
            r4_rem_x       <= (DW-1)'(w_mx >> LOW_BITS);
            r4_rem_y       <= (DW-1)'(w_my >> LOW_BITS);
            r4_low_x       <= w_mx[LOW_BITS-1:0];
            r4_low_y       <= w_my[LOW_BITS-1:0];
        end
    end

    assign o_ctl   = r4_ctl;
    assign o_den   = r4_den;
    assign o_rem_x = r4_rem_x;
    assign o_rem_y = r4_rem_y;
    assign o_low_x = r4_low_x;
    assign o_low_y = r4_low_y;

endmodule

// File: design/wpsc_div_cell.sv
// ---------------------------------------------------------------------------
// wpsc_div_cell
// One restoring division step for the x and y lanes, registered.
// ---------------------------------------------------------------------------
module wpsc_div_cell import wpsc_pkg::*; #(
    parameter int DW = 56
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_ctl                i_ctl,
    input  logic [DW-2:0]       i_den,
    input  logic [DW-2:0]       i_rem_x,
    input  logic [DW-2:0]       i_rem_y,
    input  logic [LOW_BITS-1:0] i_low_x,
    input  logic [LOW_BITS-1:0] i_low_y,
    input  logic [QBITS-1:0]    i_q_x,
    input  logic [QBITS-1:0]    i_q_y,
    output t_ctl                o_ctl,
    output logic [DW-2:0]       o_den,
    output logic [DW-2:0]       o_rem_x,
    output logic [DW-2:0]       o_rem_y,
    output logic [LOW_BITS-1:0] o_low_x,
    output logic [LOW_BITS-1:0] o_low_y,
    output logic [QBITS-1:0]    o_q_x,
    output logic [QBITS-1:0]    o_q_y
);

    logic [DW-1:0] w_tx, w_ty;
    logic          w_gx, w_gy;
    t_ctl          r_ctl;
    logic [DW-2:0] r_den, r_rem_x, r_rem_y;
    logic [LOW_BITS-1:0] r_low_x, r_low_y;
    logic [QBITS-1:0]    r_q_x, r_q_y;

    // Shift the next numerator bit into the partial remainder.
    assign w_tx = {i_rem_x, i_low_x[LOW_BITS-1]};
    assign w_ty = {i_rem_y, i_low_y[LOW_BITS-1]};
    assign w_gx = w_tx >= DW'(i_den);
    assign w_gy = w_ty >= DW'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl.visible <= i_ctl.visible;
            r_ctl.neg_x   <= i_ctl.neg_x;
            r_ctl.neg_y   <= i_ctl.neg_y;
            r_ctl.ovf_x   <= i_ctl.ovf_x;
            r_ctl.ovf_y   <= i_ctl.ovf_y;
            r_ctl.aff_x   <= i_ctl.aff_x;
            r_ctl.aff_y   <= i_ctl.aff_y;
            r_ctl.height  <= i_ctl.height;
            r_den         <= i_den;
            r_rem_x       <= w_gx ? (DW-1)'(w_tx - DW'(i_den)) : (DW-1)'(w_tx);
            r_rem_y       <= w_gy ? (DW-1)'(w_ty - DW'(i_den)) : (DW-1)'(w_ty);
            r_low_x       <= i_low_x << 1;
            r_low_y       <= i_low_y << 1;
            r_q_x         <= {i_q_x[QBITS-2:0], w_gx};
            r_q_y         <= {i_q_y[QBITS-2:0], w_gy};
        end
    end

    assign o_ctl   = r_ctl;
    assign o_den   = r_den;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_low_x = r_low_x;
    assign o_low_y = r_low_y;
    assign o_q_x   = r_q_x;
    assign o_q_y   = r_q_y;

endmodule

// File: design/world_point_to_screen_cell.sv
// ---------------------------------------------------------------------------
// world_point_to_screen_cell
// Projects a Q16.16 world point to a saturated screen cell and height.
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_stall  i_world_x, i_world_y, i_world_z
//   output   out        o_valid / i_stall  o_cell_x, o_cell_y, o_cell_height,
//                                          o_visible
//   config   in         i_cfg_we           i_cfg_index, i_cfg_data
//
// One transaction per cycle is accepted while the output is not stalled; the pipeline has
// four front stages, one divider cell per quotient bit (40) and the output register.
// The divider chain makes up most of the pipeline; every stage is registered.
// Reset is synchronous and clears all valid bits and configuration registers.
// A stall on the output holds the whole pipeline while the output is full.
// ---------------------------------------------------------------------------
module world_point_to_screen_cell import wpsc_pkg::*; #(
    parameter int CELL_SCALE   = WPSC_CELL_SCALE,
    parameter int HEIGHT_RANGE = WPSC_HEIGHT_RANGE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_world_x,
    input  logic signed [31:0] i_world_y,
    input  logic signed [31:0] i_world_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_cell_x,
    output logic signed [15:0] o_cell_y,
    output logic signed [15:0] o_cell_height,
    output logic               o_visible,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    localparam int CS_BITS = $clog2(CELL_SCALE + 1);
    localparam int DW      = 51 + CS_BITS;
    localparam int NW      = 51 + CS_BITS;
    localparam int FW      = QBITS + 3;

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MODE: begin
                    r_cfg.mode <= i_cfg_data[0];
                end
                CFG_X_COEF: begin
                    r_cfg.a0 <= i_cfg_data[31:0];
                    r_cfg.a2 <= i_cfg_data[63:32];
                end
                CFG_Y_COEF: begin
                    r_cfg.a1 <= i_cfg_data[31:0];
                    r_cfg.a3 <= i_cfg_data[63:32];
                end
                CFG_OFFSETS: begin
                    r_cfg.b0 <= i_cfg_data[31:0];
                    r_cfg.b1 <= i_cfg_data[63:32];
                end
                CFG_HEIGHT_Z: begin
                    r_cfg.a5    <= i_cfg_data[31:0];
                    r_cfg.eye_z <= i_cfg_data[63:32];
                end
                CFG_EYE_XY: begin
                    r_cfg.eye_x <= i_cfg_data[31:0];
                    r_cfg.eye_y <= i_cfg_data[63:32];
                end
                CFG_VIEW_DIR: begin
                    r_cfg.dir_x <= i_cfg_data[15:0];
                    r_cfg.dir_y <= i_cfg_data[31:16];
                    r_cfg.dir_z <= i_cfg_data[47:32];
                end
                CFG_CENTRE: begin
                    r_cfg.cen_x <= i_cfg_data[31:0];
                    r_cfg.cen_y <= i_cfg_data[63:32];
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline advance
    logic r_o_valid;
    logic w_en;

    assign w_en    = !r_o_valid || !i_stall;
    assign o_stall = !w_en;

    // divider chain, stage 0 is the front end output
    t_ctl                w_ctl   [0:QBITS];
    logic [DW-2:0]       w_den   [0:QBITS];
    logic [DW-2:0]       w_rem_x [0:QBITS];
    logic [DW-2:0]       w_rem_y [0:QBITS];
    logic [LOW_BITS-1:0] w_low_x [0:QBITS];
    logic [LOW_BITS-1:0] w_low_y [0:QBITS];
    logic [QBITS-1:0]    w_q_x   [0:QBITS];
    logic [QBITS-1:0]    w_q_y   [0:QBITS];

    assign w_q_x[0] = '0;
    assign w_q_y[0] = '0;

    wpsc_front #(
        .CELL_SCALE   (CELL_SCALE),
        .HEIGHT_RANGE (HEIGHT_RANGE),
        .DW           (DW),
        .NW           (NW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_valid),
        .i_cfg     (r_cfg),
        .i_world_x (i_world_x),
        .i_world_y (i_world_y),
        .i_world_z (i_world_z),
        .o_ctl     (w_ctl[0]),
        .o_den     (w_den[0]),
        .o_rem_x   (w_rem_x[0]),
        .o_rem_y   (w_rem_y[0]),
        .o_low_x   (w_low_x[0]),
        .o_low_y   (w_low_y[0])
    );

    for (genvar g = 0; g < QBITS; g++) begin : g_cell
        wpsc_div_cell #(
            .DW (DW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_den   (w_den[g]),
            .i_rem_x (w_rem_x[g]),
            .i_rem_y (w_rem_y[g]),
            .i_low_x (w_low_x[g]),
            .i_low_y (w_low_y[g]),
            .i_q_x   (w_q_x[g]),
            .i_q_y   (w_q_y[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_den   (w_den[g+1]),
            .o_rem_x (w_rem_x[g+1]),
            .o_rem_y (w_rem_y[g+1]),
            .o_low_x (w_low_x[g+1]),
            .o_low_y (w_low_y[g+1]),
            .o_q_x   (w_q_x[g+1]),
            .o_q_y   (w_q_y[g+1])
        );
    end

    // quotient saturation, sign and centre
    t_ctl                 w_last;
    logic [QBITS:0]       w_qm_x, w_qm_y;
    logic signed [FW-1:0] w_mag_x, w_mag_y;
    logic signed [FW-1:0] w_sx, w_sy;

    assign w_last  = w_ctl[QBITS];
    assign w_qm_x  = w_last.ovf_x ? ((QBITS+1)'(1) << QBITS) : {1'b0, w_q_x[QBITS]};
    assign w_qm_y  = w_last.ovf_y ? ((QBITS+1)'(1) << QBITS) : {1'b0, w_q_y[QBITS]};
    assign w_mag_x = FW'(w_qm_x);
    assign w_mag_y = FW'(w_qm_y);
    assign w_sx    = (w_last.neg_x ? -w_mag_x : w_mag_x) + FW'(r_cfg.cen_x);
    assign w_sy    = (w_last.neg_y ? -w_mag_y : w_mag_y) + FW'(r_cfg.cen_y);

    // output register
    logic signed [15:0] r_cell_x, r_cell_y, r_cell_height;
    logic               r_visible;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_cfg.mode) begin
                r_cell_x      <= w_last.aff_x;
                r_cell_y      <= w_last.aff_y;
                r_cell_height <= w_last.height;
                r_visible     <= 1'b1;
            end else if (!w_last.visible) begin
                r_cell_x      <= '0;
                r_cell_y      <= '0;
                r_cell_height <= '0;
                r_visible     <= 1'b0;
            end else begin
                r_cell_x      <= f_to_cell(64'(w_sx));
                r_cell_y      <= f_to_cell(64'(w_sy));
                r_cell_height <= w_last.height;
                r_visible     <= 1'b1;
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_cell_x      = r_cell_x;
    assign o_cell_y      = r_cell_y;
    assign o_cell_height = r_cell_height;
    assign o_visible     = r_visible;

endmodule

// File: design/wpsc_checker.sv
// ---------------------------------------------------------------------------
// wpsc_checker
// Port-level checks on the projection block, bound to the top level.
// ---------------------------------------------------------------------------
`include "world_point_to_screen_cell_defines.svh"

module wpsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_cell_x,
    input logic [15:0] o_cell_y,
    input logic [15:0] o_cell_height,
    input logic        o_visible
);

    // A point behind the eye carries all-zero cell fields.
    `WPSC_ASSERT(a_hidden_zero, o_valid && !o_visible |-> o_cell_x == 16'd0 && o_cell_y == 16'd0 && o_cell_height == 16'd0, "hidden point with nonzero fields")

    // The input side only stalls while a finished result is held back.
    `WPSC_ASSERT(a_stall_cause, o_stall |-> o_valid && i_stall, "input stalled without a held result")

    // The pipeline is empty right after reset.
    `WPSC_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_valid, "result right after reset")

    // A held result keeps its cell position and visibility.
    `WPSC_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_cell_x) && $stable(o_cell_y) && $stable(o_visible), "held result changed")

endmodule

bind world_point_to_screen_cell wpsc_checker u_wpsc_checker (.*);
